// ===== rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants for the CAN transport segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

    localparam int unsigned TX_STORE_BYTES_DEF = 4096;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_CHUNK = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    localparam logic [1:0] ADDR_CAPACITY = 2'd0;
    localparam logic [1:0] ADDR_BLOCK    = 2'd1;
    localparam logic [1:0] ADDR_SEP      = 2'd2;

    localparam logic [7:0] PAD_BYTE = 8'hCC;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RECV = 2'd1,
        MODE_SEND = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_READ  = 2'd1,
        ST_EMIT  = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] out_frame;
        logic [3:0]  out_dlc;
        logic [55:0] chunk;
        logic [2:0]  chunk_bytes;
        logic [11:0] chunk_offset;
        logic [11:0] message_length;
        logic        message_done;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/can_transport_segmenter_top.sv =====
// ----------------------------------------------------------------------------
// can_transport_segmenter_top
// Single-session CAN transport segmenter with byte store for transmit.
// ----------------------------------------------------------------------------
// Results for received frames appear in the cycle after acceptance; writes give none.
// Start/tick read the store one payload byte at a time, then emit the frame.
// Throughput: one item per cycle for writes and most frames while out_ready is high;
// a frame send holds off new items until its frame is queued, due to the single read port.
// Reset: asynchronous, active low; session idle, registers at default values.
`default_nettype none

module can_transport_segmenter_top
    import cts_pkg::*;
#(
    parameter int unsigned TX_STORE_BYTES = TX_STORE_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] rx_frame,
    input  wire logic [11:0] tx_index,
    input  wire logic [7:0]  tx_byte,
    input  wire logic [11:0] tx_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [63:0]      out_frame,
    output logic [3:0]       out_dlc,
    output logic [55:0]      chunk,
    output logic [2:0]       chunk_bytes,
    output logic [11:0]      chunk_offset,
    output logic [11:0]      message_length,
    output logic             message_done,
    output logic             last
);

    localparam int unsigned AW = $clog2(TX_STORE_BYTES);

    // configuration
    logic [11:0] cap_reg;
    logic [7:0]  bs_reg;
    logic [7:0]  st_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 12'd4095;
            bs_reg  <= 8'd8;
            st_reg  <= 8'd10;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                ADDR_CAPACITY: cap_reg <= pwdata[11:0];
                ADDR_BLOCK:    bs_reg  <= pwdata[7:0];
                ADDR_SEP:      st_reg  <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            ADDR_CAPACITY: prdata = {20'd0, cap_reg};
            ADDR_BLOCK:    prdata = {24'd0, bs_reg};
            ADDR_SEP:      prdata = {24'd0, st_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // transmit store
    logic [7:0]    mem [TX_STORE_BYTES];
    logic [7:0]    rd_data;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tx_index[AW-1:0]] <= tx_byte;
        rd_data <= mem[rd_addr];
    end

    // session state
    mode_t       mode_reg, mode_next;
    logic [11:0] rxt_reg, rxt_next, rxc_reg, rxc_next;
    logic [3:0]  rxs_reg, rxs_next;
    logic [7:0]  rxb_reg, rxb_next;
    logic [11:0] txt_reg, txt_next, txc_reg, txc_next;
    logic [3:0]  txs_reg, txs_next;
    logic [7:0]  txcr_reg, txcr_next;
    logic        txu_reg, txu_next;

    seq_state_t  seq_reg, seq_next;
    logic [2:0]  cnt_reg, cnt_next;      // bytes still to read
    logic [11:0] addr_reg, addr_next;    // next store address
    logic [3:0]  pos_reg, pos_next;      // frame byte position for data
    logic        rdv_reg, rdv_next;      // read data valid for write-in
    logic        rdz_reg, rdz_next;      // read beyond store
    logic [63:0] fb_reg, fb_next;

    // output queue (two entries)
    result_t     q0_reg, q0_next, q1_reg, q1_next;
    logic        v0_reg, v0_next, v1_reg, v1_next;

    logic        acc;
    logic [7:0]  b0, b1;
    logic [3:0]  ftype, flow;
    logic [11:0] ff_len, rem;
    logic [2:0]  n;
    logic [63:0] fc_cont, fc_ovf;
    logic [55:0] cdat;
    result_t     r0, r1;
    logic [1:0]  nres;
    logic        pop;

    assign pop       = v0_reg && out_ready;
    assign out_valid = v0_reg;
    assign in_ready  = (seq_reg == ST_READY) && !v1_reg && !(v0_reg && !pop);
    assign acc       = in_valid && in_ready;
    assign mem_we    = acc && (op == OP_WRITE) && (32'(tx_index) < TX_STORE_BYTES);

    assign kind           = q0_reg.kind;
    assign out_frame      = q0_reg.out_frame;
    assign out_dlc        = q0_reg.out_dlc;
    assign chunk          = q0_reg.chunk;
    assign chunk_bytes    = q0_reg.chunk_bytes;
    assign chunk_offset   = q0_reg.chunk_offset;
    assign message_length = q0_reg.message_length;
    assign message_done   = q0_reg.message_done;
    assign last           = q0_reg.last;

    assign b0      = rx_frame[63:56];
    assign b1      = rx_frame[55:48];
    assign ftype   = b0[7:4];
    assign flow    = b0[3:0];
    assign ff_len  = {flow, b1};
    assign rem     = (rxt_reg > rxc_reg) ? rxt_reg - rxc_reg : 12'd0;
    assign n       = (rem > 12'd7) ? 3'd7 : rem[2:0];
    assign fc_cont = {8'h30, bs_reg, st_reg, {5{PAD_BYTE}}};
    assign fc_ovf  = {8'h32, 8'h00, 8'h00, {5{PAD_BYTE}}};

    always_comb
    begin
        cdat = rx_frame[55:0] >> (6'(7 - 32'(n)) * 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            rxt_reg  <= '0;
            rxc_reg  <= '0;
            rxs_reg  <= '0;
            rxb_reg  <= '0;
            txt_reg  <= '0;
            txc_reg  <= '0;
            txs_reg  <= '0;
            txcr_reg <= '0;
            txu_reg  <= 1'b0;
            seq_reg  <= ST_READY;
            cnt_reg  <= '0;
            addr_reg <= '0;
            pos_reg  <= '0;
            rdv_reg  <= 1'b0;
            rdz_reg  <= 1'b0;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            rxt_reg  <= rxt_next;
            rxc_reg  <= rxc_next;
            rxs_reg  <= rxs_next;
            rxb_reg  <= rxb_next;
            txt_reg  <= txt_next;
            txc_reg  <= txc_next;
            txs_reg  <= txs_next;
            txcr_reg <= txcr_next;
            txu_reg  <= txu_next;
            seq_reg  <= seq_next;
            cnt_reg  <= cnt_next;
            addr_reg <= addr_next;
            pos_reg  <= pos_next;
            rdv_reg  <= rdv_next;
            rdz_reg  <= rdz_next;
            v0_reg   <= v0_next;
            v1_reg   <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
        fb_reg <= fb_next;
    end

    always_comb
    begin
        mode_next = mode_reg;
        rxt_next  = rxt_reg;
        rxc_next  = rxc_reg;
        rxs_next  = rxs_reg;
        rxb_next  = rxb_reg;
        txt_next  = txt_reg;
        txc_next  = txc_reg;
        txs_next  = txs_reg;
        txcr_next = txcr_reg;
        txu_next  = txu_reg;
        seq_next  = seq_reg;
        cnt_next  = cnt_reg;
        addr_next = addr_reg;
        pos_next  = pos_reg;
        rdv_next  = 1'b0;
        rdz_next  = 1'b0;
        fb_next   = fb_reg;
        rd_addr   = addr_reg[AW-1:0];
        r0        = '0;
        r1        = '0;
        nres      = 2'd0;

        case (seq_reg)
            ST_READY:
            begin
                if (acc)
                begin
                    case (op)
                        OP_FRAME:
                        begin
                            if (ftype == 4'd0)
                            begin
                                if (mode_reg == MODE_IDLE && flow != 4'd0 && flow <= 4'd7)
                                begin
                                    r0.kind           = KIND_CHUNK;
                                    r0.chunk          = rx_frame[55:0] >> (6'(7 - 32'(flow)) * 8);
                                    r0.chunk_bytes    = flow[2:0];
                                    r0.message_length = {8'd0, flow};
                                    r0.message_done   = 1'b1;
                                    r0.last           = 1'b1;
                                    nres              = 2'd1;
                                end
                            end
                            else if (ftype == 4'd1)
                            begin
                                if (mode_reg == MODE_IDLE && ff_len >= 12'd8)
                                begin
                                    if (ff_len > cap_reg)
                                    begin
                                        r0.out_frame = fc_ovf;
                                        r0.out_dlc   = 4'd8;
                                        r0.last      = 1'b1;
                                        nres         = 2'd1;
                                    end
                                    else
                                    begin
                                        mode_next = MODE_RECV;
                                        rxt_next  = ff_len;
                                        rxc_next  = 12'd6;
                                        rxs_next  = 4'd1;
                                        rxb_next  = 8'd0;
                                        r0.kind           = KIND_CHUNK;
                                        r0.chunk          = {8'd0, rx_frame[47:0]};
                                        r0.chunk_bytes    = 3'd6;
                                        r0.message_length = ff_len;
                                        r1.out_frame      = fc_cont;
                                        r1.out_dlc        = 4'd8;
                                        r1.last           = 1'b1;
                                        nres              = 2'd2;
                                    end
                                end
                            end
                            else if (ftype == 4'd2)
                            begin
                                if (mode_reg == MODE_RECV)
                                begin
                                    if (flow != rxs_reg)
                                    begin
                                        r0.kind           = KIND_ABORT;
                                        r0.chunk_offset   = rxc_reg;
                                        r0.message_length = rxt_reg;
                                        r0.last           = 1'b1;
                                        nres              = 2'd1;
                                        mode_next         = MODE_IDLE;
                                    end
                                    else
                                    begin
                                        rxc_next          = rxc_reg + 12'(n);
                                        r0.kind           = KIND_CHUNK;
                                        r0.chunk          = cdat;
                                        r0.chunk_bytes    = n;
                                        r0.chunk_offset   = rxc_reg;
                                        r0.message_length = rxt_reg;
                                        nres              = 2'd1;
                                        if (rxc_next >= rxt_reg)
                                        begin
                                            mode_next       = MODE_IDLE;
                                            r0.message_done = 1'b1;
                                            r0.last         = 1'b1;
                                        end
                                        else
                                        begin
                                            rxs_next = rxs_reg + 4'd1;
                                            rxb_next = rxb_reg + 8'd1;
                                            if (bs_reg != 8'd0 && rxb_next == bs_reg)
                                            begin
                                                rxb_next     = 8'd0;
                                                r1.out_frame = fc_cont;
                                                r1.out_dlc   = 4'd8;
                                                r1.last      = 1'b1;
                                                nres         = 2'd2;
                                            end
                                            else
                                                r0.last = 1'b1;
                                        end
                                    end
                                end
                            end
                            else if (ftype == 4'd3)
                            begin
                                if (mode_reg == MODE_SEND)
                                begin
                                    if (flow == 4'd0)
                                    begin
                                        txcr_next = b1;
                                        txu_next  = (b1 == 8'd0);
                                    end
                                    else if (flow == 4'd1)
                                    begin
                                        txcr_next = 8'd0;
                                        txu_next  = 1'b0;
                                    end
                                    else
                                        mode_next = MODE_IDLE;
                                end
                            end
                        end
                        OP_START:
                        begin
                            if (mode_reg == MODE_IDLE && tx_length != 12'd0)
                            begin
                                addr_next = 12'd0;
                                seq_next  = ST_READ;
                                if (tx_length <= 12'd7)
                                begin
                                    fb_next  = {tx_length[7:0], {7{PAD_BYTE}}};
                                    cnt_next = tx_length[2:0];
                                    pos_next = 4'd1;
                                end
                                else
                                begin
                                    fb_next   = {4'h1, tx_length[11:8], tx_length[7:0],
                                                 {6{PAD_BYTE}}};
                                    cnt_next  = 3'd6;
                                    pos_next  = 4'd2;
                                    mode_next = MODE_SEND;
                                    txt_next  = tx_length;
                                    txc_next  = 12'd6;
                                    txs_next  = 4'd1;
                                    txcr_next = 8'd0;
                                    txu_next  = 1'b0;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            if (mode_reg == MODE_SEND && (txu_reg || txcr_reg != 8'd0))
                            begin
                                fb_next   = {4'h2, txs_reg, {7{PAD_BYTE}}};
                                addr_next = txc_reg;
                                pos_next  = 4'd1;
                                seq_next  = ST_READ;
                                cnt_next  = (txt_reg - txc_reg > 12'd7) ? 3'd7
                                            : 3'(txt_reg - txc_reg);
                                txc_next  = txc_reg + ((txt_reg - txc_reg > 12'd7) ? 12'd7
                                            : txt_reg - txc_reg);
                                txs_next  = txs_reg + 4'd1;
                                if (!txu_reg)
                                    txcr_next = txcr_reg - 8'd1;
                                if (txc_next >= txt_reg)
                                    mode_next = MODE_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                // merge data from previous read
                if (rdv_reg)
                begin
                    fb_next[63 - 8*pos_reg -: 8] = rdz_reg ? 8'd0 : rd_data;
                    pos_next = pos_reg + 4'd1;
                end
                if (cnt_reg != 3'd0)
                begin
                    rd_addr   = addr_reg[AW-1:0];
                    rdv_next  = 1'b1;
                    rdz_next  = 32'(addr_reg) >= TX_STORE_BYTES;
                    addr_next = addr_reg + 12'd1;
                    cnt_next  = cnt_reg - 3'd1;
                end
                else
                    seq_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!v0_reg || pop)
                begin
                    r0.out_frame = fb_reg;
                    r0.out_dlc   = pos_reg;
                    r0.last      = 1'b1;
                    nres         = 2'd1;
                    seq_next     = ST_READY;
                end
            end
            default: seq_next = ST_READY;
        endcase
    end

    // queue update
    always_comb
    begin
        q0_next = q0_reg;
        q1_next = q1_reg;
        v0_next = v0_reg;
        v1_next = v1_reg;
        if (pop)
        begin
            q0_next = q1_reg;
            v0_next = v1_reg;
            v1_next = 1'b0;
        end
        if (nres != 2'd0)
        begin
            if (!v0_next)
            begin
                q0_next = r0;
                v0_next = 1'b1;
                if (nres == 2'd2)
                begin
                    q1_next = r1;
                    v1_next = 1'b1;
                end
            end
            else
            begin
                q1_next = r0;
                v1_next = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cts_checker.sv =====
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks for the CAN transport segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_checker
    import cts_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  kind,
    input wire logic [3:0]  out_dlc,
    input wire logic [2:0]  chunk_bytes,
    input wire logic [63:0] out_frame,
    input wire logic        pready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_frame))
        else $error("output transfer dropped");

    a_dlc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FRAME |-> out_dlc != 4'd0 && out_dlc <= 4'd8)
        else $error("bad dlc");

    a_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_CHUNK |-> chunk_bytes == 3'd0)
        else $error("chunk bytes on non-chunk");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind can_transport_segmenter_top cts_checker u_cts_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .out_dlc(out_dlc), .chunk_bytes(chunk_bytes),
    .out_frame(out_frame), .pready(pready)
);

`default_nettype wire
